>>> hdl/vas_pkg.sv
// Shared types and constants for the voice allocator.
// Holds field widths, status and opcode codes, and the controller/datapath
// command and status structs. No dependencies.
package vas_pkg;

    localparam int VOICES_DEF = 32;

    localparam int OPW  = 1;
    localparam int TAGW = 16;
    localparam int PRIW = 7;
    localparam int IDXW = 5;
    localparam int STW  = 3;

    localparam logic [OPW-1:0] OP_ALLOC = 1'b0;
    localparam logic [OPW-1:0] OP_FREE  = 1'b1;

    localparam logic [STW-1:0] ST_FROM_STACK = 3'd0;
    localparam logic [STW-1:0] ST_STOLEN     = 3'd1;
    localparam logic [STW-1:0] ST_REFUSED    = 3'd2;
    localparam logic [STW-1:0] ST_FREED      = 3'd3;
    localparam logic [STW-1:0] ST_BAD_FREE   = 3'd4;

    typedef logic [1:0] t_kind;

    localparam t_kind K_POP   = 2'd0;
    localparam t_kind K_STEAL = 2'd1;
    localparam t_kind K_FREE  = 2'd2;

    typedef struct packed {
        logic  latch;
        logic  stack_rd;
        logic  pop_take;
        logic  scan_start;
        logic  scan_step;
        logic  owner_rd;
        logic  commit;
        t_kind kind;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic empty;
        logic scan_last;
        logic slot_free;
    } t_sts;

endpackage

>>> hdl/vas_req_if.sv
// Request channel of the voice allocator: valid/ready plus request fields.
// Depends on vas_pkg for field widths.
interface vas_req_if import vas_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [OPW-1:0]  opcode;
    logic [TAGW-1:0] requester_tag;
    logic [PRIW-1:0] priority_req;
    logic [IDXW-1:0] voice_index;

    modport source (output valid, opcode, requester_tag, priority_req, voice_index,
                    input ready);
    modport sink   (input valid, opcode, requester_tag, priority_req, voice_index,
                    output ready);
endinterface

>>> hdl/vas_rsp_if.sv
// Response channel of the voice allocator: valid/ready plus result fields.
// Depends on vas_pkg for field widths.
interface vas_rsp_if import vas_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [IDXW-1:0] granted_voice;
    logic [STW-1:0]  status;
    logic [TAGW-1:0] victim_tag;

    modport source (output valid, granted_voice, status, victim_tag, input ready);
    modport sink   (input valid, granted_voice, status, victim_tag, output ready);
endinterface

>>> hdl/voice_allocator_with_stealing.sv
// Top level of the voice allocator: controller plus datapath.
// Depends on vas_pkg, vas_req_if, vas_rsp_if, vas_ctrl and vas_dpath.
//
// Usage: requests arrive on i_req (valid/ready). opcode 0 allocates a voice
// for requester_tag at priority_req, opcode 1 frees voice_index. Every
// request yields exactly one beat on o_rsp carrying granted_voice, status
// and victim_tag (nonzero only for a stolen voice).
// One request is in flight at a time; i_req.ready is high only while the
// controller waits for a new request.
// From acceptance, a free goes through dispatch to the result register; an
// allocate from the free stack first reads and pops the stack; an allocate
// with an empty stack first runs a priority scan over all voices and then
// reads the owner memory. The priority scan reads one voice per cycle
// from the priority memory through its single read port.
// A new request is accepted while the previous result still sits in the
// output register; if the receiver stalls, the next result is held in the
// controller until that register frees up.
// Reset: synchronous, active low. The free stack comes up holding every
// voice with the highest index on top, all voices idle, no result pending.
// No clearing pass is needed, so requests are taken right after reset.
module voice_allocator_with_stealing import vas_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    vas_req_if.sink    i_req,
    vas_rsp_if.source  o_rsp
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_in_ready;

    assign i_req.ready = w_in_ready;

    vas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    vas_dpath #(
        .VOICES (VOICES)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_opcode        (i_req.opcode),
        .i_requester_tag (i_req.requester_tag),
        .i_priority_req  (i_req.priority_req),
        .i_voice_index   (i_req.voice_index),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_granted_voice (o_rsp.granted_voice),
        .o_status        (o_rsp.status),
        .o_victim_tag    (o_rsp.victim_tag)
    );

`ifndef SYNTHESIS
    a_commit_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.commit |-> w_sts.slot_free)
        else $error("result committed while output register is occupied");

    a_one_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.stack_rd, w_cmd.scan_step, w_cmd.owner_rd, w_cmd.commit}))
        else $error("more than one memory operation issued in a cycle");

    a_scan_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step |-> w_sts.empty)
        else $error("priority scan running while free stack is not empty");

    a_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_STOLEN)) |-> (o_rsp.victim_tag == '0))
        else $error("victim tag set on a result that is not a steal");
`endif

endmodule

>>> hdl/vas_ctrl.sv
// Sequencing state machine of the voice allocator.
// Issues t_cmd to vas_dpath and follows its t_sts; depends on vas_pkg.
module vas_ctrl import vas_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  t_sts i_sts,
    output logic o_in_ready,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_POP      = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_SCAN_END = 3'd4;
    localparam logic [2:0] S_OWNER    = 3'd5;
    localparam logic [2:0] S_FINISH   = 3'd6;

    logic [2:0] r_state, n_state;
    t_kind      r_kind, n_kind;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        o_cmd.kind = r_kind;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_sts.op == OP_FREE) begin
                    n_kind  = K_FREE;
                    n_state = S_FINISH;
                end else if (!i_sts.empty) begin
                    o_cmd.stack_rd = 1'b1;
                    n_kind         = K_POP;
                    n_state        = S_POP;
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_kind           = K_STEAL;
                    n_state          = S_SCAN;
                end
            end
            S_POP: begin
                o_cmd.pop_take = 1'b1;
                n_state        = S_FINISH;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_SCAN_END;
                end
            end
            // last priority read compares here
            S_SCAN_END: begin
                n_state = S_OWNER;
            end
            S_OWNER: begin
                o_cmd.owner_rd = 1'b1;
                n_state        = S_FINISH;
            end
            S_FINISH: begin
                // hold until the output register can take the result
                if (i_sts.slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_kind  <= K_POP;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
        end
    end

endmodule

>>> hdl/vas_dpath.sv
// Datapath of the voice allocator: free stack, priority and owner memories,
// busy flags, priority scan and output register. Depends on vas_pkg.
module vas_dpath import vas_pkg::*; #(
    parameter int VOICES = VOICES_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    input  logic [OPW-1:0]  i_opcode,
    input  logic [TAGW-1:0] i_requester_tag,
    input  logic [PRIW-1:0] i_priority_req,
    input  logic [IDXW-1:0] i_voice_index,
    input  logic            i_out_ready,
    output logic            o_out_valid,
    output logic [IDXW-1:0] o_granted_voice,
    output logic [STW-1:0]  o_status,
    output logic [TAGW-1:0] o_victim_tag
);

    localparam int VW = $clog2(VOICES);
    localparam int CW = $clog2(VOICES + 1);
    localparam int XW = (CW > IDXW) ? CW : IDXW;

    // memories
    logic [VW-1:0]   r_stack_mem [VOICES];
    logic [PRIW-1:0] r_prio_mem  [VOICES];
    logic [TAGW-1:0] r_owner_mem [VOICES];

    // control state
    logic [CW-1:0]     r_fc, n_fc;
    logic [CW-1:0]     r_low;
    logic [VOICES-1:0] r_busy;
    logic              r_out_valid;
    logic              r_scan_vld;

    // payload
    logic [OPW-1:0]  r_opcode;
    logic [TAGW-1:0] r_tag;
    logic [PRIW-1:0] r_prio;
    logic [IDXW-1:0] r_in_idx;
    logic [VW-1:0]   r_voice;
    logic [VW-1:0]   r_stack_q;
    logic [VW-1:0]   r_stack_pos;
    logic            r_stack_hit;
    logic [PRIW-1:0] r_prio_q;
    logic [VW-1:0]   r_scan_addr;
    logic [VW-1:0]   r_scan_idx_d;
    logic [PRIW-1:0] r_lowest;
    logic            r_found;
    logic [TAGW-1:0] r_owner_q;
    logic [IDXW-1:0] r_out_voice;
    logic [STW-1:0]  r_out_status;
    logic [TAGW-1:0] r_out_tag;

    logic [VW-1:0]   w_top;
    logic [CW-1:0]   w_fc_dec;
    logic            w_free_ok;
    logic            w_scan_hit;
    logic            w_slot_free;
    logic            w_do_pop;
    logic            w_do_steal;
    logic            w_do_free;
    logic [IDXW-1:0] w_res_voice;
    logic [STW-1:0]  w_res_status;
    logic [TAGW-1:0] w_res_tag;

    assign w_fc_dec    = r_fc - 1'b1;
    assign w_top       = w_fc_dec[VW-1:0];
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign w_free_ok   = (XW'(r_in_idx) < XW'(VOICES)) && r_busy[r_voice]
                         && (r_fc < CW'(VOICES));
    assign w_scan_hit  = r_scan_vld && r_busy[r_scan_idx_d] && (r_prio_q < r_lowest);

    assign w_do_pop   = i_cmd.commit && (i_cmd.kind == K_POP);
    assign w_do_steal = i_cmd.commit && (i_cmd.kind == K_STEAL) && r_found;
    assign w_do_free  = i_cmd.commit && (i_cmd.kind == K_FREE) && w_free_ok;

    assign o_sts.op        = r_opcode[0];
    assign o_sts.empty     = (r_fc == '0);
    assign o_sts.scan_last = (r_scan_addr == VW'(VOICES - 1));
    assign o_sts.slot_free = w_slot_free;

    always_comb begin
        w_res_voice  = '0;
        w_res_status = ST_REFUSED;
        w_res_tag    = '0;
        case (i_cmd.kind)
            K_POP: begin
                w_res_voice  = IDXW'(r_voice);
                w_res_status = ST_FROM_STACK;
            end
            K_STEAL: begin
                if (r_found) begin
                    w_res_voice  = IDXW'(r_voice);
                    w_res_status = ST_STOLEN;
                    w_res_tag    = r_owner_q;
                end
            end
            K_FREE: begin
                w_res_voice  = r_in_idx;
                w_res_status = w_free_ok ? ST_FREED : ST_BAD_FREE;
            end
            default: begin
                w_res_status = ST_REFUSED;
            end
        endcase
    end

    always_comb begin
        n_fc = r_fc;
        if (w_do_pop) begin
            n_fc = w_fc_dec;
        end else if (w_do_free) begin
            n_fc = r_fc + 1'b1;
        end
    end

    // control registers; positions below r_low were never written since reset
    // and stand for their own index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc        <= CW'(VOICES);
            r_low       <= CW'(VOICES);
            r_busy      <= '0;
            r_out_valid <= 1'b0;
            r_scan_vld  <= 1'b0;
        end else begin
            r_fc       <= n_fc;
            r_scan_vld <= i_cmd.scan_step;
            if (w_do_pop && (w_fc_dec < r_low)) begin
                r_low <= w_fc_dec;
            end
            if (w_do_pop) begin
                r_busy[r_voice] <= 1'b1;
            end else if (w_do_free) begin
                r_busy[r_voice] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request latch, stack pop, priority scan and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_opcode <= i_opcode;
            r_tag    <= i_requester_tag;
            r_prio   <= i_priority_req;
            r_in_idx <= i_voice_index;
            r_voice  <= VW'(i_voice_index);
        end else if (i_cmd.pop_take) begin
            r_voice <= r_stack_hit ? r_stack_q : r_stack_pos;
        end else if (w_scan_hit) begin
            r_voice <= r_scan_idx_d;
        end
        if (i_cmd.stack_rd) begin
            r_stack_pos <= w_top;
            r_stack_hit <= (r_fc > r_low);
        end
        if (i_cmd.scan_start) begin
            r_scan_addr <= '0;
            r_lowest    <= r_prio;
            r_found     <= 1'b0;
        end else begin
            if (i_cmd.scan_step) begin
                r_scan_addr <= r_scan_addr + 1'b1;
            end
            if (w_scan_hit) begin
                r_lowest <= r_prio_q;
                r_found  <= 1'b1;
            end
        end
        r_scan_idx_d <= r_scan_addr;
        if (i_cmd.commit) begin
            r_out_voice  <= w_res_voice;
            r_out_status <= w_res_status;
            r_out_tag    <= w_res_tag;
        end
    end

    // free stack memory
    always_ff @(posedge i_clk) begin
        if (w_do_free) begin
            r_stack_mem[r_fc[VW-1:0]] <= r_voice;
        end
        if (i_cmd.stack_rd) begin
            r_stack_q <= r_stack_mem[w_top];
        end
    end

    // priority memory
    always_ff @(posedge i_clk) begin
        if (w_do_pop || w_do_steal) begin
            r_prio_mem[r_voice] <= r_prio;
        end
        if (i_cmd.scan_step) begin
            r_prio_q <= r_prio_mem[r_scan_addr];
        end
    end

    // owner memory
    always_ff @(posedge i_clk) begin
        if (w_do_pop || w_do_steal) begin
            r_owner_mem[r_voice] <= r_tag;
        end else if (w_do_free) begin
            r_owner_mem[r_voice] <= '0;
        end
        if (i_cmd.owner_rd) begin
            r_owner_q <= r_owner_mem[r_voice];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_granted_voice = r_out_voice;
    assign o_status        = r_out_status;
    assign o_victim_tag    = r_out_tag;

endmodule
